// ----- rtl/ssu_pkg.sv -----
package ssu_pkg;

    // field widths
    localparam int START_W = 60;
    localparam int LEN_W   = 16;
    localparam int PRIME_W = 32;
    localparam int BIDX_W  = 15;
    localparam int CMD_W   = 2;
    localparam int CIDX_W  = 1;
    // serial divider widths: dividend holds 30*start, divisor holds a prime
    localparam int DVD_W   = 65;
    localparam int DVS_W   = 32;
    // marking byte pointer, wide enough for one step past the segment
    localparam int STEP_W  = 33;
    // width of prime/30
    localparam int PQ_W    = 28;

    localparam logic [CMD_W-1:0] CMD_PREFILL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MARK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_START = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_LEN   = 1'b1;

    localparam logic [PRIME_W-1:0] MIN_PRIME       = 32'd17;
    localparam logic [7:0]         ZERO_START_BYTE = 8'h01;
    localparam logic [LEN_W-1:0]   LEN_RESET       = 16'd32768;

    // 30 mod 7, 30 mod 11, 30 mod 13
    localparam logic [3:0] M7  = 4'd7;
    localparam logic [3:0] M11 = 4'd11;
    localparam logic [3:0] M13 = 4'd13;
    localparam logic [3:0] K7  = 4'd2;
    localparam logic [3:0] K11 = 4'd8;
    localparam logic [3:0] K13 = 4'd4;

    function automatic logic [4:0] wheel_res(input logic [2:0] k);
        logic [4:0] r;
        unique case (k)
            3'd0: r = 5'd1;
            3'd1: r = 5'd7;
            3'd2: r = 5'd11;
            3'd3: r = 5'd13;
            3'd4: r = 5'd17;
            3'd5: r = 5'd19;
            3'd6: r = 5'd23;
            default: r = 5'd29;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] wheel_gap(input logic [2:0] k);
        logic [2:0] g;
        unique case (k)
            3'd0: g = 3'd6;
            3'd1: g = 3'd4;
            3'd2: g = 3'd2;
            3'd3: g = 3'd4;
            3'd4: g = 3'd2;
            3'd5: g = 3'd4;
            3'd6: g = 3'd6;
            default: g = 3'd2;
        endcase
        return g;
    endfunction

    // bit position of a residue coprime to 30
    function automatic logic [2:0] bit_of_res(input logic [4:0] r);
        logic [2:0] b;
        unique case (r)
            5'd7:  b = 3'd1;
            5'd11: b = 3'd2;
            5'd13: b = 3'd3;
            5'd17: b = 3'd4;
            5'd19: b = 3'd5;
            5'd23: b = 3'd6;
            5'd29: b = 3'd7;
            default: b = 3'd0;
        endcase
        return b;
    endfunction

    function automatic logic is_wheel(input logic [4:0] r);
        return (r == 5'd1) || (r == 5'd7) || (r == 5'd11) || (r == 5'd13) ||
               (r == 5'd17) || (r == 5'd19) || (r == 5'd23) || (r == 5'd29);
    endfunction

    // index of the first wheel residue at or above r
    function automatic logic [2:0] ceil_idx(input logic [4:0] r);
        logic [2:0] k;
        if (r < 5'd2)       k = 3'd0;
        else if (r < 5'd8)  k = 3'd1;
        else if (r < 5'd12) k = 3'd2;
        else if (r < 5'd14) k = 3'd3;
        else if (r < 5'd18) k = 3'd4;
        else if (r < 5'd20) k = 3'd5;
        else if (r < 5'd24) k = 3'd6;
        else                k = 3'd7;
        return k;
    endfunction

    // reduce v < 3*m into [0, m)
    function automatic logic [3:0] mod_sub2(input logic [5:0] v, input logic [3:0] m);
        logic [5:0] t;
        t = v;
        if (t >= {2'b00, m}) t = t - {2'b00, m};
        if (t >= {2'b00, m}) t = t - {2'b00, m};
        return t[3:0];
    endfunction

    function automatic logic is_mult(input logic [5:0] s, input logic [3:0] m);
        logic h;
        h = 1'b0;
        for (int k = 1; k <= 6; k++) begin
            if ({1'b0, s} == 7'(k * m)) h = 1'b1;
        end
        return h;
    endfunction

    // presieve byte from the residues of 30*d mod 7, 11, 13
    function automatic logic [7:0] presieve_bits(input logic [3:0] c7, input logic [3:0] c11,
                                                 input logic [3:0] c13);
        logic [7:0] v;
        logic [5:0] s7, s11, s13;
        v = 8'h00;
        for (int i = 0; i < 8; i++) begin
            s7  = {2'b00, c7}  + {1'b0, wheel_res(3'(i))};
            s11 = {2'b00, c11} + {1'b0, wheel_res(3'(i))};
            s13 = {2'b00, c13} + {1'b0, wheel_res(3'(i))};
            v[i] = is_mult(s7, M7) || is_mult(s11, M11) || is_mult(s13, M13);
        end
        return v;
    endfunction

    // v / 30 for v below 210
    function automatic logic [2:0] div30_small(input logic [7:0] v);
        logic [2:0] q;
        q = 3'd0;
        for (int k = 1; k <= 6; k++) begin
            if (v >= 8'(30 * k)) q = 3'(k);
        end
        return q;
    endfunction

    // v / 30 for any 32-bit v: (v/2) * ceil(2^35/15) >> 35
    function automatic logic [31:0] div30(input logic [31:0] v);
        logic [63:0] prod;
        prod = {33'b0, v[31:1]} * 64'h0000_0000_8888_8889;
        return {3'b000, prod[63:35]};
    endfunction

endpackage

// ----- rtl/ssu_div.sv -----
// Restoring divider, one quotient bit per cycle, MSB first.
// Also tracks the quotient modulo 30 as its bits come out.
module ssu_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [ssu_pkg::DVD_W-1:0] dividend,
    input  logic [ssu_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [ssu_pkg::DVD_W-1:0] quo,
    output logic [ssu_pkg::DVS_W-1:0] rem,
    output logic [4:0]                quo_mod30
);
    import ssu_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [4:0]       qm_reg, qm_next;

    logic [DVS_W:0] trial;
    logic           qbit;
    logic [5:0]     qm2;

    // one restoring step
    always_comb begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
        qm2   = {qm_reg, qbit};
        if (qm2 >= 6'd30) qm2 = qm2 - 6'd30;
    end

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        qm_next   = qm_reg;
        if (start) begin
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
            dvd_next  = dividend;
            dvs_next  = divisor;
            quo_next  = '0;
            rem_next  = '0;
            qm_next   = 5'd0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[DVD_W-2:0], qbit};
            rem_next = qbit ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            qm_next  = qm2[4:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        qm_reg  <= qm_next;
    end

    assign done      = done_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;
    assign quo_mod30 = qm_reg;

endmodule

// ----- rtl/ssu_bitmap.sv -----
// Segment bitmap: one write port, one read port, registered read data.
module ssu_bitmap #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mod30_wheel_segment_sieve_unit.sv -----
// Segmented sieve over a mod-30 wheel. The bitmap holds one byte per 30
// integers (bit i = residue 1,7,11,13,17,19,23,29) in a single-port-write,
// single-port-read RAM with registered read data; one word is taken at a
// time and yields one result word. Prefill scans the segment start, MSB
// first, for its residues mod 7, 11 and 13, then writes one byte per cycle.
// Mark first runs a one-bit-per-cycle 65-bit divider for 30*start/prime (the
// divisions by 30 are combinational reciprocal multiplies), then visits
// each wheel multiple inside the segment, the bitmap RAM doing one
// read-modify-write per cycle. Read fetches the byte from the bitmap into a
// register. A new word is taken as soon as the result of the previous one
// sits in the output register.
module mod30_wheel_segment_sieve_unit #(
    parameter int SEG_BYTES = 32768
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ssu_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [ssu_pkg::START_W-1:0]  cfg_data,
    // command words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ssu_pkg::CMD_W-1:0]    s_cmd,
    input  logic [ssu_pkg::PRIME_W-1:0]  s_prime,
    input  logic [ssu_pkg::BIDX_W-1:0]   s_byte_index,
    // result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_read_byte,
    output logic                         m_status
);
    import ssu_pkg::*;

    localparam int AW = (SEG_BYTES > 1) ? $clog2(SEG_BYTES) : 1;
    localparam int LW = $clog2(SEG_BYTES + 1);
    localparam int CW = (LW > LEN_W) ? LW : LEN_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PSCAN = 4'd1;
    localparam logic [3:0] ST_PFILL = 4'd2;
    localparam logic [3:0] ST_DIVP  = 4'd3;
    localparam logic [3:0] ST_DIVS  = 4'd4;
    localparam logic [3:0] ST_OFFS  = 4'd5;
    localparam logic [3:0] ST_SUMO  = 4'd6;
    localparam logic [3:0] ST_CMPO  = 4'd7;
    localparam logic [3:0] ST_DIVO  = 4'd8;
    localparam logic [3:0] ST_MARK  = 4'd9;
    localparam logic [3:0] ST_RD    = 4'd10;
    localparam logic [3:0] ST_RDW   = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    // configuration registers
    logic [START_W-1:0] start_reg;
    logic [LEN_W-1:0]   len_reg;

    logic [3:0]          state_reg, state_next;
    logic [PRIME_W-1:0]  p_reg, p_next;
    logic [BIDX_W-1:0]   bidx_reg, bidx_next;
    logic [7:0]          rbyte_reg, rbyte_next;
    logic                rst_reg, rst_next;
    logic                go_reg, go_next;

    // prefill state
    logic [5:0]    scan_reg, scan_next;
    logic [3:0]    c7_reg, c7_next, c11_reg, c11_next, c13_reg, c13_next;
    logic [LW-1:0] j_reg, j_next;

    // mark state
    logic [PQ_W-1:0]    pq_reg, pq_next;
    logic [4:0]         pr_reg, pr_next;
    logic               sq_sel_reg, sq_sel_next;
    logic [63:0]        sq_reg, sq_next;
    logic [34:0]        pd_reg, pd_next;
    logic [PRIME_W-1:0] base_reg, base_next;
    logic [63:0]        off_reg, off_next;
    logic [STEP_W-1:0]  idx_reg, idx_next;
    logic [4:0]         res_reg, res_next;
    logic [2:0]         k_reg, k_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic [7:0]         pend_mask_reg, pend_mask_next;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic       m_st_reg, m_st_next;

    // divider
    logic               div_done;
    logic [DVD_W-1:0]   div_quo;
    logic [DVS_W-1:0]   div_rem;
    logic [4:0]         div_qm;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;

    // memory ports
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    // derived values
    logic [CW-1:0]      len_ext;
    logic [LW-1:0]      alen;
    logic [LW+4:0]      lim;
    logic [DVD_W-1:0]   s30;
    logic               rnz;
    logic [DVD_W:0]     q0;
    logic               q_lt_p;
    logic [5:0]         r_sum;
    logic [4:0]         r_sel;
    logic [2:0]         k_sel;
    logic [2:0]         delta;
    logic [2:0]         gap;
    logic [7:0]         gsum;
    logic [2:0]         gcq;
    logic [30:0]        ginc;
    logic [31:0]        p_q30, o_q30;
    logic [4:0]         p_r30, o_r30;
    logic               mark_go;
    logic               out_free;
    logic               accept;

    // active length saturates at the bitmap depth
    always_comb begin
        len_ext = CW'(len_reg);
        if (len_ext > CW'(SEG_BYTES)) len_ext = CW'(SEG_BYTES);
        alen = len_ext[LW-1:0];
        lim  = {alen, 5'b0} - {4'b0, alen, 1'b0};
    end

    assign s30 = {start_reg, 5'b0} - {4'b0, start_reg, 1'b0};

    // divisions by 30; remainder from the low bits since -30*q = 2*q mod 32
    always_comb begin
        p_q30 = div30(p_reg);
        p_r30 = p_reg[4:0] + {p_q30[3:0], 1'b0};
        o_q30 = div30(off_reg[31:0]);
        o_r30 = off_reg[4:0] + {o_q30[3:0], 1'b0};
    end

    // first wheel multiple
    always_comb begin
        rnz    = (div_rem != '0);
        q0     = {1'b0, div_quo} + (DVD_W + 1)'(rnz);
        q_lt_p = (q0 < (DVD_W + 1)'(p_reg));
        r_sum  = {1'b0, div_qm} + 6'(rnz);
        if (r_sum >= 6'd30) r_sum = r_sum - 6'd30;
        r_sel  = q_lt_p ? pr_reg : r_sum[4:0];
        k_sel  = ceil_idx(r_sel);
        delta  = 3'(wheel_res(k_sel) - r_sel);
    end

    // one wheel step: offset += gap*p, kept as byte index and residue
    always_comb begin
        gap  = wheel_gap(k_reg);
        gsum = ({5'b0, gap} * {3'b0, pr_reg}) + {3'b0, res_reg};
        gcq  = div30_small(gsum);
        ginc = ({28'b0, gap} * {3'b0, pq_reg}) + {28'b0, gcq};
    end

    assign mark_go  = (state_reg == ST_MARK) && (idx_reg < STEP_W'(alen));
    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    // divider computes 30*start / prime
    assign div_dvd = s30;
    assign div_dvs = p_reg;

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = mem_rdata | pend_mask_reg;
        mem_re    = 1'b0;
        mem_raddr = idx_reg[AW-1:0];
        if (state_reg == ST_PFILL) begin
            mem_we    = (j_reg < alen);
            mem_waddr = j_reg[AW-1:0];
            mem_wdata = ((j_reg == '0) && (start_reg == '0)) ? ZERO_START_BYTE :
                        presieve_bits(c7_reg, c11_reg, c13_reg);
        end else if (state_reg == ST_MARK) begin
            mem_we = pend_vld_reg;
            mem_re = mark_go;
        end else if (state_reg == ST_RD) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(bidx_reg);
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        p_next         = p_reg;
        bidx_next      = bidx_reg;
        rbyte_next     = rbyte_reg;
        rst_next       = rst_reg;
        go_next        = 1'b0;
        scan_next      = scan_reg;
        c7_next        = c7_reg;
        c11_next       = c11_reg;
        c13_next       = c13_reg;
        j_next         = j_reg;
        pq_next        = pq_reg;
        pr_next        = pr_reg;
        sq_sel_next    = sq_sel_reg;
        sq_next        = sq_reg;
        pd_next        = pd_reg;
        base_next      = base_reg;
        off_next       = off_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        k_next         = k_reg;
        pend_vld_next  = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_mask_next = pend_mask_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_byte_next    = m_byte_reg;
        m_st_next      = m_st_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    p_next     = s_prime;
                    bidx_next  = s_byte_index;
                    rbyte_next = 8'h00;
                    rst_next   = 1'b0;
                    case (s_cmd)
                        CMD_PREFILL: begin
                            scan_next  = 6'(START_W - 1);
                            c7_next    = 4'd0;
                            c11_next   = 4'd0;
                            c13_next   = 4'd0;
                            state_next = ST_PSCAN;
                        end
                        CMD_MARK: begin
                            if (s_prime < MIN_PRIME) begin
                                rst_next   = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_DIVP;
                            end
                        end
                        CMD_READ: begin
                            if (32'(s_byte_index) < 32'(SEG_BYTES)) state_next = ST_RD;
                            else                                    state_next = ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            // residues of 30*start mod 7, 11, 13, MSB first
            ST_PSCAN: begin
                c7_next  = mod_sub2({1'b0, c7_reg, 1'b0} +
                                    (start_reg[scan_reg] ? {2'b0, K7} : 6'd0), M7);
                c11_next = mod_sub2({1'b0, c11_reg, 1'b0} +
                                    (start_reg[scan_reg] ? {2'b0, K11} : 6'd0), M11);
                c13_next = mod_sub2({1'b0, c13_reg, 1'b0} +
                                    (start_reg[scan_reg] ? {2'b0, K13} : 6'd0), M13);
                scan_next = scan_reg - 6'd1;
                if (scan_reg == 6'd0) begin
                    j_next     = '0;
                    state_next = ST_PFILL;
                end
            end
            ST_PFILL: begin
                if (j_reg < alen) begin
                    j_next   = j_reg + LW'(1);
                    c7_next  = mod_sub2({2'b0, c7_reg} + {2'b0, K7}, M7);
                    c11_next = mod_sub2({2'b0, c11_reg} + {2'b0, K11}, M11);
                    c13_next = mod_sub2({2'b0, c13_reg} + {2'b0, K13}, M13);
                end else begin
                    state_next = ST_DONE;
                end
            end
            // prime / 30: residue class and step sizes
            ST_DIVP: begin
                pq_next = p_q30[PQ_W-1:0];
                pr_next = p_r30;
                if (!is_wheel(p_r30)) begin
                    state_next = ST_DONE;
                end else begin
                    go_next    = 1'b1;
                    state_next = ST_DIVS;
                end
            end
            // 30*start / prime
            ST_DIVS: begin
                if (div_done) state_next = ST_OFFS;
            end
            ST_OFFS: begin
                sq_sel_next = q_lt_p;
                sq_next     = p_reg * p_reg;
                pd_next     = 35'(p_reg) * 35'(delta);
                base_next   = rnz ? (p_reg - div_rem) : '0;
                k_next      = k_sel;
                state_next  = ST_SUMO;
            end
            ST_SUMO: begin
                off_next   = sq_sel_reg ? (sq_reg - s30[63:0]) :
                             (64'(base_reg) + 64'(pd_reg));
                state_next = ST_CMPO;
            end
            ST_CMPO: begin
                if (off_reg < 64'(lim)) begin
                    state_next = ST_DIVO;
                end else begin
                    state_next = ST_DONE;
                end
            end
            // first offset split into byte index and residue
            ST_DIVO: begin
                idx_next   = STEP_W'(o_q30);
                res_next   = o_r30;
                state_next = ST_MARK;
            end
            // read now, merge and write back next cycle
            ST_MARK: begin
                if (mark_go) begin
                    pend_vld_next  = 1'b1;
                    pend_addr_next = idx_reg[AW-1:0];
                    pend_mask_next = 8'(1) << bit_of_res(res_reg);
                    idx_next       = idx_reg + STEP_W'(ginc);
                    res_next       = 5'(gsum - 8'(30 * gcq));
                    k_next         = k_reg + 3'd1;
                end else if (!pend_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_RD: begin
                state_next = ST_RDW;
            end
            ST_RDW: begin
                rbyte_next = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = rbyte_reg;
                    m_st_next    = rst_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            len_reg   <= LEN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_START: start_reg <= cfg_data;
                CFG_LEN:   len_reg   <= cfg_data[LEN_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            go_reg       <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            go_reg       <= go_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        p_reg         <= p_next;
        bidx_reg      <= bidx_next;
        rbyte_reg     <= rbyte_next;
        rst_reg       <= rst_next;
        scan_reg      <= scan_next;
        c7_reg        <= c7_next;
        c11_reg       <= c11_next;
        c13_reg       <= c13_next;
        j_reg         <= j_next;
        pq_reg        <= pq_next;
        pr_reg        <= pr_next;
        sq_sel_reg    <= sq_sel_next;
        sq_reg        <= sq_next;
        pd_reg        <= pd_next;
        base_reg      <= base_next;
        off_reg       <= off_next;
        idx_reg       <= idx_next;
        res_reg       <= res_next;
        k_reg         <= k_next;
        pend_addr_reg <= pend_addr_next;
        pend_mask_reg <= pend_mask_next;
        m_byte_reg    <= m_byte_next;
        m_st_reg      <= m_st_next;
    end

    ssu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (go_reg),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quo       (div_quo),
        .rem       (div_rem),
        .quo_mod30 (div_qm)
    );

    ssu_bitmap #(
        .DEPTH (SEG_BYTES),
        .AW    (AW)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_read_byte = m_byte_reg;
    assign m_status    = m_st_reg;

endmodule

// ----- tb/sieve_checker.sv -----
`timescale 1ns / 1ps

// Watches the config, command and result channels, keeps its own copy of the
// segment bitmap and checks every result word in order.
module sieve_checker #(
    parameter int SEG_BYTES = 32768
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [ssu_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [ssu_pkg::START_W-1:0]  cfg_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [ssu_pkg::CMD_W-1:0]    s_cmd,
    input  logic [ssu_pkg::PRIME_W-1:0]  s_prime,
    input  logic [ssu_pkg::BIDX_W-1:0]   s_byte_index,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [7:0]                   m_read_byte,
    input  logic                         m_status,
    output int                           mismatches,
    output int                           pending
);
    import ssu_pkg::*;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       status;
    } sieve_result_t;

    localparam int SPOKE[8] = '{1, 7, 11, 13, 17, 19, 23, 29};
    localparam int GAP[8]   = '{6, 4, 2, 4, 2, 4, 6, 2};

    logic [7:0]            seg_map [SEG_BYTES];
    logic [START_W-1:0]    seg_start;
    logic [LEN_W-1:0]      seg_len;
    sieve_result_t         result_q[$];

    assign pending = result_q.size();

    function automatic int used_len();
        if (seg_len > SEG_BYTES) return SEG_BYTES;
        return int'(seg_len);
    endfunction

    // composite flags of wheel byte d from the 7/11/13 presieve
    function automatic logic [7:0] presieve_of(longint unsigned d);
        logic [7:0] v;
        longint unsigned n;
        v = '0;
        for (int i = 0; i < 8; i++) begin
            n = 30 * d + SPOKE[i];
            if (n % 7 == 0 || n % 11 == 0 || n % 13 == 0) v[i] = 1'b1;
        end
        return v;
    endfunction

    task automatic fill_segment();
        longint unsigned d;
        d = seg_start % 1001;
        for (int j = 0; j < used_len(); j++) begin
            seg_map[j] = presieve_of(d);
            d = (d == 1000) ? 0 : d + 1;
        end
        if (seg_start == 0 && used_len() > 0) seg_map[0] = ZERO_START_BYTE;
    endtask

    // set the bits of every wheel multiple p*q, q >= p, inside the segment
    task automatic cross_out(logic [PRIME_W-1:0] prime);
        logic [127:0] pp, a, b, qlo, q, t, off, lim, idx;
        int r, k, res, bpos;
        pp = prime;
        if (pp % 2 == 0 || pp % 3 == 0 || pp % 5 == 0) return;
        a   = seg_start / pp;
        b   = seg_start % pp;
        qlo = 30 * a + (30 * b + pp - 1) / pp;
        q   = (qlo < pp) ? pp : qlo;
        r   = int'(q % 30);
        k   = 0;
        while (SPOKE[k] < r) k++;
        q   = q - r + SPOKE[k];
        t   = q - 30 * a;
        off = pp * t - 30 * b;
        lim = 30 * used_len();
        while (off < lim) begin
            idx  = off / 30;
            res  = int'(off % 30);
            bpos = 0;
            while (SPOKE[bpos] != res) bpos++;
            seg_map[idx][bpos] = 1'b1;
            off = off + pp * GAP[k];
            k = (k + 1) % 8;
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("[%0t] result mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    initial mismatches = 0;

    always @(posedge aclk) begin
        sieve_result_t want;
        if (aresetn) begin
            // config writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_START) seg_start = cfg_data;
                else seg_len = cfg_data[LEN_W-1:0];
            end
            // command word: predict its result now
            if (s_valid && s_ready) begin
                want = '0;
                case (s_cmd)
                    CMD_PREFILL: fill_segment();
                    CMD_MARK: begin
                        if (s_prime < MIN_PRIME) want.status = 1'b1;
                        else cross_out(s_prime);
                    end
                    CMD_READ: begin
                        if (int'(s_byte_index) < SEG_BYTES)
                            want.read_byte = seg_map[s_byte_index];
                    end
                    default: ;
                endcase
                result_q.push_back(want);
            end
            // result word
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    report("word with nothing outstanding", int'(m_read_byte), 0);
                end else begin
                    want = result_q.pop_front();
                    if (m_read_byte !== want.read_byte)
                        report("read_byte", m_read_byte, want.read_byte);
                    if (m_status !== want.status)
                        report("status", m_status, want.status);
                end
            end
        end else begin
            seg_start = '0;
            seg_len   = LEN_RESET;
            result_q.delete();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ssu_pkg::*;

    localparam int SEG_BYTES = 32768;
    localparam longint unsigned START_MAX = 64'd614891469123651720;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CIDX_W-1:0]     cfg_index;
    logic [START_W-1:0]    cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd;
    logic [PRIME_W-1:0]    s_prime;
    logic [BIDX_W-1:0]     s_byte_index;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_read_byte;
    logic                  m_status;
    int                    mismatches;
    int                    pending;

    int                    tx_idle;
    int                    rx_idle;
    int                    stall_req;
    int                    stall_seen;
    int                    stall_left;
    int                    cur_len;

    mod30_wheel_segment_sieve_unit #(.SEG_BYTES(SEG_BYTES)) dut (.*);

    sieve_checker #(.SEG_BYTES(SEG_BYTES)) u_checker (.*);

    // 12 ns clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side: random back-pressure, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
            stall_seen <= 0;
        end else if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            stall_left <= 1500;
            m_ready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // one command word; valid stays up after acceptance until the next call or a drop
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [PRIME_W-1:0] prime,
                             logic [BIDX_W-1:0] bidx);
        if ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_prime      <= prime;
        s_byte_index <= bidx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drain, let the block settle, then write both registers
    task automatic set_segment(longint unsigned start, logic [LEN_W-1:0] len);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_START;
        cfg_data  <= start[START_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_LEN;
        cfg_data  <= START_W'(len);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_len = (len == 0) ? 1 : (len > SEG_BYTES ? SEG_BYTES : len);
    endtask

    function automatic logic [PRIME_W-1:0] pick_prime(int big_seg);
        int sel;
        logic [PRIME_W-1:0] p;
        sel = $urandom_range(99);
        if (sel < 8)       p = $urandom_range(16);
        else if (sel < 16) p = 30 * $urandom_range(1000, 1) + 5 * $urandom_range(1);
        else if (sel < 40 || big_seg) p = $urandom | 32'h1;
        else               p = 2 * $urandom_range(1000, 8) + 1;
        return p;
    endfunction

    function automatic longint unsigned pick_start();
        int sel;
        longint unsigned x;
        sel = $urandom_range(9);
        x = {$urandom, $urandom};
        if (sel == 0) return 0;
        if (sel == 1) return START_MAX;
        if (sel < 4) return 64'($urandom_range(3000));
        return x % (START_MAX + 1);
    endfunction

    task automatic random_phase(int n_items);
        int sel;
        int big_seg;
        logic [LEN_W-1:0] len;
        int done;
        done = 0;
        while (done < n_items) begin
            sel = $urandom_range(19);
            big_seg = (sel == 0);
            if (sel == 0)      len = 16'd65535;
            else if (sel == 1) len = 16'd0;
            else               len = LEN_W'($urandom_range(600, 1));
            set_segment(pick_start(), len);
            send_word(CMD_PREFILL, $urandom, BIDX_W'($urandom));
            done++;
            repeat ($urandom_range(14, 6)) begin
                sel = $urandom_range(99);
                if (sel < 45)
                    send_word(CMD_MARK, pick_prime(big_seg), BIDX_W'($urandom));
                else if (sel < 90)
                    send_word(CMD_READ, $urandom,
                              ($urandom_range(9) == 0) ? BIDX_W'($urandom)
                                                       : BIDX_W'($urandom_range(cur_len - 1)));
                else if (sel < 95)
                    send_word(CMD_UNUSED, $urandom, BIDX_W'($urandom));
                else
                    send_word(CMD_PREFILL, $urandom, BIDX_W'($urandom));
                done++;
            end
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_START;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_cmd        = CMD_READ;
        s_prime      = '0;
        s_byte_index = '0;
        stall_req    = 0;
        tx_idle      = 0;
        rx_idle      = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: whole bitmap presieved from zero, then edge primes
        set_segment(0, 16'd32768);
        send_word(CMD_PREFILL, '1, '1);
        send_word(CMD_READ, '0, 15'd0);
        send_word(CMD_READ, '0, 15'd32767);
        send_word(CMD_MARK, 32'd17, '0);
        send_word(CMD_MARK, 32'd16, '0);
        send_word(CMD_MARK, 32'd0, '0);
        send_word(CMD_MARK, 32'd25, '0);
        send_word(CMD_MARK, 32'hFFFF_FFFF, '0);
        send_word(CMD_MARK, 32'd4294967291, '0);
        send_word(CMD_UNUSED, '1, '1);
        send_word(CMD_READ, '0, 15'd9);
        send_word(CMD_READ, '0, 15'd12345);

        // top of the start range, single byte
        set_segment(START_MAX, 16'd1);
        send_word(CMD_PREFILL, '0, '0);
        send_word(CMD_MARK, 32'd4294967291, '0);
        send_word(CMD_MARK, 32'd49, '0);
        send_word(CMD_READ, '0, 15'd0);
        send_word(CMD_READ, '0, 15'd1);

        // zero length, then saturated length with a large prime
        set_segment(1001, 16'd0);
        send_word(CMD_PREFILL, '0, '0);
        send_word(CMD_MARK, 32'd19, '0);
        send_word(CMD_READ, '0, 15'd0);
        set_segment(77, 16'hFFFF);
        send_word(CMD_PREFILL, '0, '0);
        send_word(CMD_MARK, 32'd65521, '0);
        send_word(CMD_READ, '0, 15'd32767);

        // long receiver hold-off while reads keep coming
        set_segment(5, 16'd64);
        send_word(CMD_PREFILL, '0, '0);
        stall_req <= stall_req + 1;
        repeat (20) send_word(CMD_READ, $urandom, BIDX_W'($urandom_range(63)));

        tx_idle = 22; rx_idle = 64;
        random_phase(30);
        tx_idle = 64; rx_idle = 22;
        random_phase(30);
        tx_idle = 0; rx_idle = 0;
        random_phase(30);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
